### sv/shdlc_pkg.sv
package shdlc_pkg;

    localparam logic [7:0] FLAG_BYTE   = 8'h7E;
    localparam logic [7:0] ESC_BYTE    = 8'h7D;
    localparam logic [7:0] XON_CODE    = 8'h11;
    localparam logic [7:0] XOFF_CODE   = 8'h13;
    localparam logic [7:0] FLAG_SUB    = 8'h5E;
    localparam logic [7:0] ESC_SUB     = 8'h5D;
    localparam logic [7:0] XON_SUB     = 8'h31;
    localparam logic [7:0] XOFF_SUB    = 8'h33;
    localparam logic [7:0] INVERT_MASK = 8'hFF;

    localparam int MAX_BEATS   = 6;
    localparam int BEAT_CNT_W  = $clog2(MAX_BEATS + 1);
    localparam int BEAT_IDX_W  = $clog2(MAX_BEATS);

    typedef struct packed {
        logic [7:0] content_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] wire_byte;
        logic       frame_end;
    } t_out_beat;

    typedef struct packed {
        t_out_beat [MAX_BEATS-1:0] beats;
        logic [BEAT_CNT_W-1:0]     count;
    } t_frag;

    typedef struct packed {
        logic       escape;
        logic [7:0] value;
    } t_stuffed;

    function automatic t_stuffed stuff_byte(input logic [7:0] b);
        t_stuffed s;
        s.escape = 1'b1;
        unique case (b)
            FLAG_BYTE: s.value = FLAG_SUB;
            ESC_BYTE:  s.value = ESC_SUB;
            XON_CODE:  s.value = XON_SUB;
            XOFF_CODE: s.value = XOFF_SUB;
            default: begin
                s.escape = 1'b0;
                s.value  = b;
            end
        endcase
        return s;
    endfunction

endpackage

### sv/shdlc_expand.sv
module shdlc_expand (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  shdlc_pkg::t_in_beat i_beat,
    output shdlc_pkg::t_frag    o_frag
);
    import shdlc_pkg::*;

    logic [7:0]            r_sum;
    logic [7:0]            n_sum;
    logic [7:0]            sum_next;
    t_stuffed              data_st;
    t_stuffed              check_st;
    t_frag                 frag;
    logic [BEAT_CNT_W-1:0] n;

    always_comb begin
        sum_next = (i_beat.first_byte ? 8'h00 : r_sum) + i_beat.content_byte;
        n_sum    = i_beat.last_byte ? 8'h00 : sum_next;
        data_st  = stuff_byte(i_beat.content_byte);
        check_st = stuff_byte(sum_next ^ INVERT_MASK);
    end

    always_comb begin
        frag = '0;
        n    = '0;
        if (i_beat.first_byte) begin
            frag.beats[n[BEAT_IDX_W-1:0]] = '{wire_byte: FLAG_BYTE, frame_end: 1'b0};
            n = n + 1'b1;
        end
        if (data_st.escape) begin
            frag.beats[n[BEAT_IDX_W-1:0]] = '{wire_byte: ESC_BYTE, frame_end: 1'b0};
            n = n + 1'b1;
        end
        frag.beats[n[BEAT_IDX_W-1:0]] = '{wire_byte: data_st.value, frame_end: 1'b0};
        n = n + 1'b1;
        if (i_beat.last_byte) begin
            if (check_st.escape) begin
                frag.beats[n[BEAT_IDX_W-1:0]] = '{wire_byte: ESC_BYTE, frame_end: 1'b0};
                n = n + 1'b1;
            end
            frag.beats[n[BEAT_IDX_W-1:0]] = '{wire_byte: check_st.value, frame_end: 1'b0};
            n = n + 1'b1;
            frag.beats[n[BEAT_IDX_W-1:0]] = '{wire_byte: FLAG_BYTE, frame_end: 1'b1};
            n = n + 1'b1;
        end
        frag.count = n;
    end

    assign o_frag = frag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= 8'h00;
        end else if (i_accept) begin
            r_sum <= n_sum;
        end
    end

endmodule

### sv/shdlc_serial.sv
module shdlc_serial (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  shdlc_pkg::t_frag     i_frag,
    output logic                o_free,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output shdlc_pkg::t_out_beat o_out_beat
);
    import shdlc_pkg::*;

    logic                  r_valid;
    logic                  n_valid;
    logic [BEAT_IDX_W-1:0] r_idx;
    logic [BEAT_IDX_W-1:0] n_idx;
    t_frag                 r_frag;
    logic                  take;
    logic                  done;
    logic [BEAT_CNT_W-1:0] last_idx;

    always_comb begin
        last_idx = r_frag.count - 1'b1;
        take     = r_valid && i_out_ready;
        done     = take && (BEAT_CNT_W'(r_idx) == last_idx);
        o_free   = !r_valid || done;
        n_valid  = i_load ? 1'b1 : (done ? 1'b0 : r_valid);
        if (i_load || done) begin
            n_idx = '0;
        end else if (take) begin
            n_idx = r_idx + 1'b1;
        end else begin
            n_idx = r_idx;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_beat  = r_frag.beats[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_frag <= i_frag;
        end
    end

endmodule

### sv/shdlc_frame_encoder.sv
// The first line byte of an input beat appears in the cycle after the beat is accepted.
// An input beat produces 1 to 6 line bytes, which leave one per cycle while the output
// is ready; a content byte inside a frame produces 1, or 2 when it is escaped. The single
// output byte lane sets this rate.
// The next input beat is taken in the cycle the last line byte of the previous one leaves.
// Reset is synchronous and active low; it empties the output stage, zeroes the sum and
// holds the input not ready.
module shdlc_frame_encoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  shdlc_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output shdlc_pkg::t_out_beat o_out_beat
);
    import shdlc_pkg::*;

    t_frag frag;
    logic  free;
    logic  accept;

    assign o_in_ready = free && i_rst_n;
    assign accept     = i_in_valid && o_in_ready;

    shdlc_expand u_expand (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_beat   (i_in_beat),
        .o_frag   (frag)
    );

    shdlc_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_frag      (frag),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

endmodule
